### src/indexed_insert_remove_list_top_macros.svh
// Assertion macros shared by the checker.
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IIRL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked during reset as well.
`define IIRL_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/iirl_pkg.sv
`default_nettype none
package iirl_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int MODE_W     = 3;
  localparam int POS_W      = 7;
  localparam int CNT_W      = 7;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 3'd0,
    MODE_APPEND  = 3'd1,
    MODE_PREPEND = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
  } in_data_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_word;
    logic [CNT_W-1:0]    entry_count;
  } out_data_t;

  // Request from the control to the cell row.
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic                  rd;
    logic [POS_W-1:0]      pos;
    logic [ELEM_WIDTH-1:0] value;
  } chain_req_t;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_LOW  = 2'd2,
    CELL_FROM_HIGH = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_hit;
  } cell_ctl_t;

endpackage
`default_nettype wire

### src/iirl_cell.sv
`default_nettype none
module iirl_cell (
  input  wire                                 clk,
  input  iirl_pkg::cell_ctl_t                 ctl,
  input  wire [iirl_pkg::ELEM_WIDTH-1:0]      word_lo,
  input  wire [iirl_pkg::ELEM_WIDTH-1:0]      word_hi,
  input  wire [iirl_pkg::ELEM_WIDTH-1:0]      load_word,
  output logic [iirl_pkg::ELEM_WIDTH-1:0]     word_q,
  output logic [iirl_pkg::ELEM_WIDTH-1:0]     rd_word
);

  logic [iirl_pkg::ELEM_WIDTH-1:0] word_r;
  logic [iirl_pkg::ELEM_WIDTH-1:0] word_nxt;

  always_comb begin
    unique case (ctl.op)
      iirl_pkg::CELL_HOLD:      word_nxt = word_r;
      iirl_pkg::CELL_LOAD:      word_nxt = load_word;
      iirl_pkg::CELL_FROM_LOW:  word_nxt = word_lo;
      iirl_pkg::CELL_FROM_HIGH: word_nxt = word_hi;
      default:                  word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q  = word_r;
  // drive the shared read bus only when addressed
  assign rd_word = ctl.rd_hit ? word_r : '0;

endmodule
`default_nettype wire

### src/iirl_chain.sv
`default_nettype none
module iirl_chain (
  input  wire                              clk,
  input  iirl_pkg::chain_req_t             req,
  output logic [iirl_pkg::ELEM_WIDTH-1:0]  rd_word
);

  localparam int Cap = iirl_pkg::CAPACITY;

  iirl_pkg::cell_ctl_t             ctl     [Cap];
  logic [iirl_pkg::ELEM_WIDTH-1:0] word_q  [Cap];
  logic [iirl_pkg::ELEM_WIDTH-1:0] word_lo [Cap];
  logic [iirl_pkg::ELEM_WIDTH-1:0] word_hi [Cap];
  logic [iirl_pkg::ELEM_WIDTH-1:0] cell_rd [Cap];

  // Each cell decides from its own place relative to the position.
  always_comb begin
    for (int k = 0; k < Cap; k++) begin
      ctl[k].op     = iirl_pkg::CELL_HOLD;
      ctl[k].rd_hit = req.rd && (req.pos == iirl_pkg::POS_W'(k));
      if (req.ins) begin
        if (req.pos == iirl_pkg::POS_W'(k)) begin
          ctl[k].op = iirl_pkg::CELL_LOAD;
        end else if (iirl_pkg::POS_W'(k) > req.pos) begin
          ctl[k].op = iirl_pkg::CELL_FROM_LOW;
        end
      end else if (req.rem && (k < Cap - 1) && (iirl_pkg::POS_W'(k) >= req.pos)) begin
        ctl[k].op = iirl_pkg::CELL_FROM_HIGH;
      end
    end
  end

  for (genvar k = 0; k < Cap; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign word_lo[k] = '0;
    end else begin : g_lo
      assign word_lo[k] = word_q[k-1];
    end
    if (k == Cap - 1) begin : g_last
      assign word_hi[k] = '0;
    end else begin : g_hi
      assign word_hi[k] = word_q[k+1];
    end

    iirl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[k]),
      .word_lo   (word_lo[k]),
      .word_hi   (word_hi[k]),
      .load_word (req.value),
      .word_q    (word_q[k]),
      .rd_word   (cell_rd[k])
    );
  end

  // at most one cell drives a nonzero word
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < Cap; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

endmodule
`default_nettype wire

### src/indexed_insert_remove_list_top.sv
// Indexed insert/remove list: an ordered list of up to 64 words of 32 bits.
// Input channel in_valid/in_ready/in_data carries one request: insert at a
// position, append, prepend, remove at a position, or read at a position.
// Output channel out_valid/out_ready/out_data returns one result per request:
// status (done, position out of range, list full), the word read, and the
// entry count after the request.
// The result is registered into the output register in the cycle after the
// request is accepted. Throughput: one request per cycle while results are
// taken; every cell of the row shifts, loads or holds in the same cycle, so
// the row takes one step. The read word is selected from the row before the
// same edge updates it. When the receiver stalls, the result holds in the
// output register and in_ready drops until it is taken; a new request is
// accepted in the same cycle that the waiting result leaves.
// Reset (rst_n low, synchronous) clears the entry count and the output
// valid; the cell contents stay as they were and are never read before an
// insert writes them.
`default_nettype none
module indexed_insert_remove_list_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  iirl_pkg::in_data_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output iirl_pkg::out_data_t  out_data
);

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  iirl_pkg::out_data_t           out_data_r;
  iirl_pkg::out_data_t           out_data_nxt;
  logic [iirl_pkg::CNT_W-1:0]    count_r;
  logic [iirl_pkg::CNT_W-1:0]    count_nxt;

  logic                          accept;
  logic                          is_put;
  logic [iirl_pkg::POS_W-1:0]    put_pos;
  iirl_pkg::status_t             status;
  logic                          do_ins;
  logic                          do_rem;
  logic                          do_rd;
  iirl_pkg::chain_req_t          req;
  logic [iirl_pkg::ELEM_WIDTH-1:0] rd_word;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_put  = 1'b0;
    put_pos = in_data.position;
    status  = iirl_pkg::ST_DONE;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_rd   = 1'b0;
    unique case (in_data.mode)
      iirl_pkg::MODE_INSERT: begin
        is_put = 1'b1;
      end
      iirl_pkg::MODE_APPEND: begin
        is_put  = 1'b1;
        put_pos = count_r;
      end
      iirl_pkg::MODE_PREPEND: begin
        is_put  = 1'b1;
        put_pos = '0;
      end
      iirl_pkg::MODE_REMOVE: begin
        if (in_data.position >= count_r) begin
          status = iirl_pkg::ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      iirl_pkg::MODE_READ: begin
        if (in_data.position >= count_r) begin
          status = iirl_pkg::ST_RANGE;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // range check comes before the full check
    if (is_put) begin
      priority if (put_pos > count_r) begin
        status = iirl_pkg::ST_RANGE;
      end else if (count_r == iirl_pkg::CNT_W'(iirl_pkg::CAPACITY)) begin
        status = iirl_pkg::ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end
  end

  always_comb begin
    req.ins   = accept && do_ins;
    req.rem   = accept && do_rem;
    req.rd    = do_rd;
    req.pos   = put_pos;
    req.value = in_data.value[iirl_pkg::ELEM_WIDTH-1:0];
  end

  iirl_chain u_chain (
    .clk     (clk),
    .req     (req),
    .rd_word (rd_word)
  );

  always_comb begin
    count_nxt = count_r;
    if (req.ins) begin
      count_nxt = count_r + iirl_pkg::CNT_W'(1);
    end else if (req.rem) begin
      count_nxt = count_r - iirl_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = status;
      out_data_nxt.read_word   = do_rd ? iirl_pkg::WORD_W'(rd_word) : '0;
      out_data_nxt.entry_count = count_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### src/iirl_checker.sv
`default_nettype none
`include "indexed_insert_remove_list_top_macros.svh"
module iirl_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input iirl_pkg::in_data_t   in_data,
  input wire                  out_valid,
  input wire                  out_ready,
  input iirl_pkg::out_data_t  out_data
);

  `IIRL_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "result valid right after reset")
  `IIRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `IIRL_ASSERT_IMPL(a_stall_blocks, out_valid && !out_ready, !in_ready, "request taken while result stalled")
  `IIRL_ASSERT_IMPL(a_fail_zero, out_valid && (out_data.status != iirl_pkg::ST_DONE), out_data.read_word == '0, "failed request returned a word")
  `IIRL_ASSERT_IMPL(a_full_count, out_valid && (out_data.status == iirl_pkg::ST_FULL), out_data.entry_count == iirl_pkg::CNT_W'(iirl_pkg::CAPACITY), "full status below capacity")

endmodule

bind indexed_insert_remove_list_top iirl_checker u_iirl_checker (.*);
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import iirl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 650;
  localparam int REPORT_MAX  = 10;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int MODE_MAX    = (1 << MODE_W) - 1;

  localparam int SEG_GROW   = 0;
  localparam int SEG_SHRINK = 1;
  localparam int SEG_MIX    = 2;

  localparam int RDY_ALWAYS = 0;
  localparam int RDY_COIN   = 1;
  localparam int RDY_EVERY4 = 2;
  localparam int RDY_MOSTLY = 3;

  typedef struct packed {
    logic     wait_drain;
    in_data_t req;
  } queued_op_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_data_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  indexed_insert_remove_list_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Shadow of the list held by the block.
  logic [ELEM_WIDTH-1:0] list_words [CAPACITY];
  int                    list_len = 0;

  queued_op_t queued_ops[$];
  out_data_t  awaited_results[$];
  out_data_t  oldest;
  int         gen_len    = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  logic       req_taken  = 1'b0;

  int gap_left    = 0;
  int burst_left  = 1;
  int ready_mode  = RDY_ALWAYS;
  int ready_left  = 0;
  int ready_phase = 0;

  function automatic status_t insert_word(input int pos, input logic [WORD_W-1:0] word);
    if (pos > list_len) return ST_RANGE;
    if (list_len >= CAPACITY) return ST_FULL;
    for (int k = list_len; k > pos; k--) list_words[k] = list_words[k - 1];
    list_words[pos] = word;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic out_data_t list_op(input in_data_t req);
    out_data_t res;
    res = '0;
    res.status = ST_DONE;
    case (req.mode)
      MODE_INSERT:  res.status = insert_word(int'(req.position), req.value);
      MODE_APPEND:  res.status = insert_word(list_len, req.value);
      MODE_PREPEND: res.status = insert_word(0, req.value);
      MODE_REMOVE: begin
        if (int'(req.position) < list_len) begin
          for (int k = int'(req.position); k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      MODE_READ: begin
        if (int'(req.position) < list_len) begin
          res.read_word = WORD_W'(list_words[req.position[$clog2(CAPACITY)-1:0]]);
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(list_len);
    return res;
  endfunction

  function automatic void queue_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                   input logic [WORD_W-1:0] word, input bit wait_drain);
    queued_op_t op;
    op.wait_drain   = wait_drain;
    op.req.mode     = mode;
    op.req.position = pos;
    op.req.value    = word;
    queued_ops.push_back(op);
    // track the count so positions can be aimed inside the list
    case (mode)
      MODE_INSERT:               if (int'(pos) <= gen_len && gen_len < CAPACITY) gen_len++;
      MODE_APPEND, MODE_PREPEND: if (gen_len < CAPACITY) gen_len++;
      MODE_REMOVE:               if (int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  // Request driver: bursts with random gaps, hold while not taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_taken) void'(queued_ops.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_ops.size() == 0 ||
                   (queued_ops[0].wait_drain && awaited_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= queued_ops[0].req;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
          gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end
      end
    end
  end

  // Result receiver: switch between stall patterns every so often.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(RDY_MOSTLY, RDY_ALWAYS);
      ready_left = $urandom_range(200, 20);
    end else begin
      ready_left--;
    end
    ready_phase++;
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(1, 0));
      RDY_EVERY4: out_ready <= (ready_phase % 4 == 0);
      default:    out_ready <= ($urandom_range(7, 0) != 0);
    endcase
  end

  // Monitor: check the result first, then predict the request taken at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("result with none awaited: status %0d word %h count %0d",
                     out_data.status, out_data.read_word, out_data.entry_count);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data.status !== oldest.status || out_data.read_word !== oldest.read_word ||
              out_data.entry_count !== oldest.entry_count) begin
            if (fail_count < REPORT_MAX)
              $display("mismatch: expected status %0d word %h count %0d, got status %0d word %h count %0d",
                       oldest.status, oldest.read_word, oldest.entry_count,
                       out_data.status, out_data.read_word, out_data.entry_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(list_op(in_data));
      req_taken <= in_valid && in_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int        seg_kind;
    int        seg_len;
    int        add_w;
    int        rem_w;
    int        pick;
    int        roll;
    int        random_left;
    mode_t     mode;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;

    // empty list: positional requests are out of range at first, then the list grows
    queue_op(MODE_READ,    '0, '0, 1'b0);
    queue_op(MODE_REMOVE,  '0, '1, 1'b0);
    queue_op(MODE_INSERT,  POS_W'(1), 32'h1234_5678, 1'b0);
    queue_op(MODE_INSERT,  '0, '1, 1'b0);
    queue_op(MODE_APPEND,  POS_W'(POS_MAX), '0, 1'b0);
    queue_op(MODE_PREPEND, POS_W'(POS_MAX), 32'hA5A5_A5A5, 1'b0);
    queue_op(MODE_INSERT,  POS_W'(1), 32'h5A5A_5A5A, 1'b0);
    // insert at the count lands at the tail
    queue_op(MODE_INSERT,  POS_W'(4), 32'h0000_0001, 1'b0);
    queue_op(MODE_READ,    '0, '1, 1'b0);
    queue_op(MODE_READ,    POS_W'(4), '0, 1'b0);
    queue_op(MODE_READ,    POS_W'(5), '0, 1'b0);
    queue_op(MODE_READ,    POS_W'(POS_MAX), '0, 1'b0);
    queue_op(MODE_INSERT,  POS_W'(POS_MAX), 32'hDEAD_BEEF, 1'b0);
    queue_op(MODE_REMOVE,  POS_W'(POS_MAX), '0, 1'b0);
    queue_op(MODE_REMOVE,  POS_W'(1), '0, 1'b0);
    queue_op(MODE_REMOVE,  POS_W'(3), '0, 1'b0);
    queue_op(MODE_REMOVE,  '0, '0, 1'b0);
    queue_op(MODE_READ,    POS_W'(1), '0, 1'b0);
    // unused modes leave the list alone
    queue_op(MODE_W'(MODE_READ + 1), POS_W'(POS_MAX), '1, 1'b0);
    queue_op(MODE_W'(MODE_READ + 2), '0, 32'h8000_0000, 1'b0);
    queue_op(MODE_W'(MODE_MAX), POS_W'(1), '0, 1'b0);
    queue_op(MODE_READ,    '0, '0, 1'b0);

    // segments lean toward growing, shrinking or a mix; the first fills the list
    random_left = RANDOM_OPS;
    seg_kind    = SEG_GROW;
    seg_len     = 120;
    while (random_left > 0) begin
      case (seg_kind)
        SEG_GROW:   begin add_w = 85; rem_w = 5;  end
        SEG_SHRINK: begin add_w = 10; rem_w = 70; end
        default:    begin add_w = 40; rem_w = 30; end
      endcase
      for (int i = 0; i < seg_len && random_left > 0; i++) begin
        roll = $urandom_range(9, 0);
        word = (roll == 0) ? '0 : (roll == 1) ? '1 : WORD_W'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 3) begin
          queue_op(MODE_W'($urandom_range(MODE_MAX, MODE_READ + 1)), POS_W'($urandom), word, i == 0);
        end else begin
          pick = $urandom_range(99, 0);
          roll = $urandom_range(9, 0);
          if (pick < add_w) begin
            case ($urandom_range(2, 0))
              0:       mode = MODE_INSERT;
              1:       mode = MODE_APPEND;
              default: mode = MODE_PREPEND;
            endcase
            pos = (roll == 0 || mode != MODE_INSERT) ? POS_W'($urandom)
                                                     : POS_W'($urandom_range(gen_len, 0));
          end else begin
            mode = (pick < add_w + rem_w) ? MODE_REMOVE : MODE_READ;
            pos  = (roll == 0 || gen_len == 0) ? POS_W'($urandom)
                                               : POS_W'($urandom_range(gen_len - 1, 0));
          end
          queue_op(mode, pos, word, i == 0);
          random_left--;
        end
      end
      seg_kind = $urandom_range(SEG_MIX, SEG_GROW);
      seg_len  = $urandom_range(120, 30);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (queued_ops.size() != 0) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
